// File: src/lbochk_pkg.sv
// ============================================================================
// lbochk_pkg: shared types, class codes and rule functions
// Holds the class encoding, the table entry layout, the sequencer states and
// the fixed line-break rule chain that works on two code points.
// ============================================================================
package lbochk_pkg;

    localparam int CP_W  = 21;
    localparam int CLS_W = 6;

    typedef logic [CP_W-1:0]  t_cp;
    typedef logic [CLS_W-1:0] t_cls;

    // Class codes. Codes above OP are carried through and match no class rule.
    localparam t_cls CLS_AL = 6'd0;
    localparam t_cls CLS_ID = 6'd1;
    localparam t_cls CLS_SP = 6'd2;
    localparam t_cls CLS_NS = 6'd3;
    localparam t_cls CLS_HY = 6'd4;
    localparam t_cls CLS_OP = 6'd5;

    // Input action codes.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        t_cp  low;
        t_cp  high;
        t_cls cls;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PROBE  = 4'b0010,
        ST_CHECK  = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    function automatic logic in_rng(input t_cp c, input t_cp a, input t_cp b);
        return (c >= a) && (c <= b);
    endfunction

    function automatic logic is_combining(input t_cp c);
        return in_rng(c, 21'h000300, 21'h00036F) || in_rng(c, 21'h001AB0, 21'h001AFF) ||
               in_rng(c, 21'h001DC0, 21'h001DFF) || in_rng(c, 21'h0020D0, 21'h0020FF) ||
               in_rng(c, 21'h00FE20, 21'h00FE2F);
    endfunction

    function automatic logic is_extender(input t_cp c);
        return in_rng(c, 21'h00FE00, 21'h00FE0F) || in_rng(c, 21'h0E0100, 21'h0E01EF) ||
               in_rng(c, 21'h01F3FB, 21'h01F3FF) || in_rng(c, 21'h0E0020, 21'h0E007F) ||
               (c == 21'h00200D);
    endfunction

    function automatic logic is_glue(input t_cp c);
        return (c == 21'h0000A0) || (c == 21'h002007) || (c == 21'h00202F) ||
               (c == 21'h002060);
    endfunction

    function automatic logic is_regional(input t_cp c);
        return in_rng(c, 21'h01F1E6, 21'h01F1FF);
    endfunction

    function automatic logic is_digit(input t_cp c);
        return in_rng(c, 21'h000030, 21'h000039) || in_rng(c, 21'h000660, 21'h000669) ||
               in_rng(c, 21'h0006F0, 21'h0006F9) || in_rng(c, 21'h00FF10, 21'h00FF19);
    endfunction

    function automatic logic is_separator(input t_cp c);
        return (c == 21'h00002E) || (c == 21'h00002C) || (c == 21'h00066B) ||
               (c == 21'h00066C) || (c == 21'h00FF0E) || (c == 21'h00FF0C);
    endfunction

    function automatic logic is_heb_letter(input t_cp c);
        return in_rng(c, 21'h0005D0, 21'h0005EA) || in_rng(c, 21'h0005F0, 21'h0005F2);
    endfunction

    function automatic logic is_heb_quote(input t_cp c);
        return (c == 21'h000027) || (c == 21'h000022) || (c == 21'h0005F3) ||
               (c == 21'h0005F4);
    endfunction

    // Rule chain; the first rule that matches decides.
    function automatic logic break_rule(input t_cp p, input t_cp c,
                                        input t_cls pc, input t_cls cc);
        logic brk;
        priority if (is_combining(c))                                 brk = 1'b0;
        else if (is_extender(p) || is_extender(c))                   brk = 1'b0;
        else if (is_glue(p) || is_glue(c))                           brk = 1'b0;
        else if ((is_heb_letter(p) && is_heb_quote(c)) ||
                 (is_heb_quote(p) && is_heb_letter(c)))              brk = 1'b0;
        else if (is_separator(c) && is_digit(p))                     brk = 1'b0;
        else if (is_separator(p) && is_digit(c))                     brk = 1'b0;
        else if (is_regional(p) && is_regional(c))                   brk = 1'b0;
        else if (cc == CLS_SP)                                       brk = 1'b1;
        else if (cc == CLS_NS)                                       brk = 1'b0;
        else if ((pc == CLS_SP) || (pc == CLS_HY))                   brk = 1'b1;
        else if ((cc == CLS_HY) || (pc == CLS_OP))                   brk = 1'b0;
        else if ((pc == CLS_AL) && (cc == CLS_AL))                   brk = 1'b0;
        else                                                         brk = 1'b1;
        return brk;
    endfunction

endpackage

// File: src/line_break_opportunity_check_core.sv
// ============================================================================
// line_break_opportunity_check_core: range-table line-break opportunity test
// A load item writes one (low, high, class) entry into the range table and
// gives no result. A query item classifies the previous and the current code
// point by two binary searches that run side by side on the two read ports of
// the table, then applies the fixed rule chain and gives one result item. Each
// search step is a table read in the probe state followed by the compare and
// bound update in the check state. The input is stalled while a query is in
// flight, and a finished result waits in the output register while the next
// item is taken. A code point that falls in no range gets class ID. The table
// has no reset; entries must be loaded before they are searched, and
// entries_in_use may only be written while the block is idle.
// ============================================================================
module line_break_opportunity_check_core #(
    parameter int TABLE_DEPTH = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: number of table entries searched
    input  logic                 i_cfg_we,
    input  logic [11:0]          i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [10:0]          i_entry_index,
    input  lbochk_pkg::t_cp      i_entry_low,
    input  lbochk_pkg::t_cp      i_entry_high,
    input  lbochk_pkg::t_cls     i_entry_class,
    input  lbochk_pkg::t_cp      i_prev_code_point,
    input  lbochk_pkg::t_cp      i_cur_code_point,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_break_allowed,
    output lbochk_pkg::t_cls     o_prev_class,
    output lbochk_pkg::t_cls     o_cur_class
);
    import lbochk_pkg::*;

    // Address width of the table, and a bound width that can hold the depth.
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int NW   = AW + 1;
    localparam int CMPW = (NW > 12) ? NW : 12;
    localparam int IW   = (NW > 11) ? NW : 11;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(TABLE_DEPTH);
    localparam logic [IW-1:0]   DEPTH_I = IW'(TABLE_DEPTH);

    // Lane 0 searches the previous code point, lane 1 the current one.
    localparam int LANES = 2;

    t_entry          r_mem [TABLE_DEPTH];
    t_entry          r_rd  [LANES];

    t_state          r_state, n_state;
    logic [11:0]     r_entries_in_use;

    t_cp             r_cp   [LANES];
    logic [NW-1:0]   r_lo   [LANES];
    logic [NW-1:0]   n_lo   [LANES];
    logic [NW-1:0]   r_hi   [LANES];
    logic [NW-1:0]   n_hi   [LANES];
    logic            r_done [LANES];
    logic            n_done [LANES];
    t_cls            r_cls  [LANES];
    t_cls            n_cls  [LANES];

    logic            r_out_valid;
    logic            r_break;
    t_cls            r_prev_cls;
    t_cls            r_cur_cls;

    logic [CMPW-1:0] w_cfg_ext;
    logic [NW-1:0]   w_count;
    logic [IW-1:0]   w_idx_ext;
    logic            w_accept;
    logic            w_load_we;
    logic            w_out_load;
    logic            w_busy_next;
    logic            w_break;
    logic [NW-1:0]   w_mid    [LANES];
    logic            w_active [LANES];

    // A count above the table depth searches the whole table.
    assign w_cfg_ext = CMPW'(r_entries_in_use);
    assign w_count   = (w_cfg_ext > DEPTH_C) ? NW'(DEPTH_C) : NW'(w_cfg_ext);

    assign w_accept  = i_in_valid && (r_state == ST_IDLE);
    assign w_idx_ext = IW'(i_entry_index);
    // Loads aimed beyond the table are dropped.
    assign w_load_we = w_accept && (i_action == ACT_LOAD) && (w_idx_ext < DEPTH_I);

    assign w_out_load = (r_state == ST_RESULT) && (!r_out_valid || !i_out_stall);
    assign w_break    = break_rule(r_cp[0], r_cp[1], r_cls[0], r_cls[1]);

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_mid[k]    = r_lo[k] + ((r_hi[k] - r_lo[k]) >> 1);
            w_active[k] = !r_done[k] && (r_lo[k] < r_hi[k]);
        end
    end

    // Table: one write port for loads, two read ports for the searches.
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            r_mem[w_idx_ext[AW-1:0]] <= '{low: i_entry_low, high: i_entry_high,
                                          cls: i_entry_class};
        end
        if (r_state == ST_PROBE) begin
            r_rd[0] <= r_mem[w_mid[0][AW-1:0]];
            r_rd[1] <= r_mem[w_mid[1][AW-1:0]];
        end
    end

    // Search step: compare the probed entry and narrow the bounds.
    always_comb begin
        w_busy_next = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            n_lo[k]   = r_lo[k];
            n_hi[k]   = r_hi[k];
            n_done[k] = r_done[k];
            n_cls[k]  = r_cls[k];
            if (r_state == ST_CHECK && w_active[k]) begin
                if (r_cp[k] < r_rd[k].low) begin
                    n_hi[k] = w_mid[k];
                end else if (r_cp[k] > r_rd[k].high) begin
                    n_lo[k] = w_mid[k] + NW'(1);
                end else begin
                    n_done[k] = 1'b1;
                    n_cls[k]  = r_rd[k].cls;
                end
            end
            if (!n_done[k] && (n_lo[k] < n_hi[k])) begin
                w_busy_next = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_action == ACT_QUERY)) begin
                    n_state = (w_count != '0) ? ST_PROBE : ST_RESULT;
                end
            end
            ST_PROBE: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = w_busy_next ? ST_PROBE : ST_RESULT;
            end
            ST_RESULT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_entries_in_use <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_entries_in_use <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Search lanes and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_action == ACT_QUERY)) begin
            r_cp[0] <= i_prev_code_point;
            r_cp[1] <= i_cur_code_point;
            for (int k = 0; k < LANES; k++) begin
                r_lo[k]   <= '0;
                r_hi[k]   <= w_count;
                r_done[k] <= 1'b0;
                r_cls[k]  <= CLS_ID;
            end
        end else begin
            for (int k = 0; k < LANES; k++) begin
                r_lo[k]   <= n_lo[k];
                r_hi[k]   <= n_hi[k];
                r_done[k] <= n_done[k];
                r_cls[k]  <= n_cls[k];
            end
        end
        if (w_out_load) begin
            r_break    <= w_break;
            r_prev_cls <= r_cls[0];
            r_cur_cls  <= r_cls[1];
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_break_allowed = r_break;
    assign o_prev_class    = r_prev_cls;
    assign o_cur_class     = r_cur_cls;

    // The search window never inverts while a query is in flight.
    a_lane0_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE || r_state == ST_CHECK) |-> (r_lo[0] <= r_hi[0]))
        else $error("lane 0 search window inverted");

    a_lane1_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE || r_state == ST_CHECK) |-> (r_lo[1] <= r_hi[1]))
        else $error("lane 1 search window inverted");

    // Every table read is followed by its compare step.
    a_probe_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |=> (r_state == ST_CHECK))
        else $error("probe not followed by compare");

    // A result only appears after the rule chain has been evaluated.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_RESULT))
        else $error("result raised outside the result state");

    // Once lane 0 has found its range, a compare step leaves its class unchanged.
    a_found_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && r_done[0]) |=> $stable(r_cls[0]))
        else $error("found class changed during search");

endmodule

// File: verif/lbochk_break_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// lbochk_break_checker: prediction and comparison for the line-break checker
// Follows loads and register writes into its own copy of the range table,
// works out the classes and the break flag for every accepted query, and
// compares each result item with the oldest prediction still waiting.
// ============================================================================
module lbochk_break_checker #(
    parameter int TABLE_DEPTH = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [11:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_action,
    input  logic [10:0]          i_entry_index,
    input  lbochk_pkg::t_cp      i_entry_low,
    input  lbochk_pkg::t_cp      i_entry_high,
    input  lbochk_pkg::t_cls     i_entry_class,
    input  lbochk_pkg::t_cp      i_prev_code_point,
    input  lbochk_pkg::t_cp      i_cur_code_point,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_break_allowed,
    input  lbochk_pkg::t_cls     i_prev_class,
    input  lbochk_pkg::t_cls     i_cur_class,
    output int                   o_fail_count,
    output int                   o_pending_count
);
    import lbochk_pkg::*;

    typedef struct {
        t_cp  prev_cp;
        t_cp  cur_cp;
        logic brk;
        t_cls prev_cls;
        t_cls cur_cls;
    } t_break_expect;

    t_entry        range_copy [TABLE_DEPTH];
    logic [11:0]   entry_count = '0;
    t_break_expect break_queue [$];
    int            mismatches = 0;

    function automatic bit in_span(input t_cp c, input int a, input int b);
        return (c >= a) && (c <= b);
    endfunction

    function automatic bit mark_cp(input t_cp c);
        return in_span(c, 'h0300, 'h036F) || in_span(c, 'h1AB0, 'h1AFF) ||
               in_span(c, 'h1DC0, 'h1DFF) || in_span(c, 'h20D0, 'h20FF) ||
               in_span(c, 'hFE20, 'hFE2F);
    endfunction

    // Variation selectors, skin-tone modifiers, tags and the zero-width joiner.
    function automatic bit joiner_cp(input t_cp c);
        return in_span(c, 'hFE00, 'hFE0F) || in_span(c, 'hE0100, 'hE01EF) ||
               in_span(c, 'h1F3FB, 'h1F3FF) || in_span(c, 'hE0020, 'hE007F) ||
               (c == 21'h00200D);
    endfunction

    function automatic bit glue_cp(input t_cp c);
        case (c)
            21'h0000A0, 21'h002007, 21'h00202F, 21'h002060: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit digit_cp(input t_cp c);
        return in_span(c, 'h30, 'h39) || in_span(c, 'h0660, 'h0669) ||
               in_span(c, 'h06F0, 'h06F9) || in_span(c, 'hFF10, 'hFF19);
    endfunction

    function automatic bit decimal_sep_cp(input t_cp c);
        case (c)
            21'h00002E, 21'h00002C, 21'h00066B, 21'h00066C, 21'h00FF0E, 21'h00FF0C:
                return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit heb_letter_cp(input t_cp c);
        return in_span(c, 'h05D0, 'h05EA) || in_span(c, 'h05F0, 'h05F2);
    endfunction

    function automatic bit heb_quote_cp(input t_cp c);
        case (c)
            21'h000027, 21'h000022, 21'h0005F3, 21'h0005F4: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Binary search over the entries in use; a miss gives the ideographic class.
    function automatic t_cls lookup_class(input t_cp cp);
        int lo_i;
        int hi_i;
        int mid;
        lo_i = 0;
        hi_i = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        while (lo_i < hi_i) begin
            mid = lo_i + (hi_i - lo_i) / 2;
            if (cp < range_copy[mid].low) begin
                hi_i = mid;
            end else if (cp > range_copy[mid].high) begin
                lo_i = mid + 1;
            end else begin
                return range_copy[mid].cls;
            end
        end
        return CLS_ID;
    endfunction

    // First matching rule decides; 1 means a break is allowed.
    function automatic logic break_verdict(input t_cp p, input t_cp c,
                                           input t_cls pc, input t_cls cc);
        if (mark_cp(c)) return 1'b0;
        if (joiner_cp(p) || joiner_cp(c)) return 1'b0;
        if (glue_cp(p) || glue_cp(c)) return 1'b0;
        if ((heb_letter_cp(p) && heb_quote_cp(c)) || (heb_quote_cp(p) && heb_letter_cp(c)))
            return 1'b0;
        if ((digit_cp(p) && decimal_sep_cp(c)) || (decimal_sep_cp(p) && digit_cp(c)))
            return 1'b0;
        if (in_span(p, 'h1F1E6, 'h1F1FF) && in_span(c, 'h1F1E6, 'h1F1FF)) return 1'b0;
        if (cc == CLS_SP) return 1'b1;
        if (cc == CLS_NS) return 1'b0;
        if ((pc == CLS_SP) || (pc == CLS_HY)) return 1'b1;
        if ((cc == CLS_HY) || (pc == CLS_OP)) return 1'b0;
        if ((pc == CLS_AL) && (cc == CLS_AL)) return 1'b0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_break_expect want;
        if (!i_rst_n) begin
            entry_count = '0;
            break_queue.delete();
        end else begin
            // Results are matched before a new query is queued, so a result
            // that shows up with no query behind it cannot hide.
            if (i_out_valid && !i_out_stall) begin
                if (break_queue.size() == 0) begin
                    $display("%0t: result item with nothing expected: brk %0d classes %0d %0d",
                             $time, i_break_allowed, i_prev_class, i_cur_class);
                    mismatches++;
                end else begin
                    want = break_queue.pop_front();
                    if (i_break_allowed !== want.brk) begin
                        $display("%0t: break_allowed for %h,%h expected %0d actual %0d",
                                 $time, want.prev_cp, want.cur_cp, want.brk, i_break_allowed);
                        mismatches++;
                    end
                    if (i_prev_class !== want.prev_cls) begin
                        $display("%0t: prev_class for %h expected %0d actual %0d",
                                 $time, want.prev_cp, want.prev_cls, i_prev_class);
                        mismatches++;
                    end
                    if (i_cur_class !== want.cur_cls) begin
                        $display("%0t: cur_class for %h expected %0d actual %0d",
                                 $time, want.cur_cp, want.cur_cls, i_cur_class);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                entry_count = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_action == ACT_LOAD) begin
                    if (i_entry_index < TABLE_DEPTH) begin
                        range_copy[i_entry_index].low  = i_entry_low;
                        range_copy[i_entry_index].high = i_entry_high;
                        range_copy[i_entry_index].cls  = i_entry_class;
                    end
                end else begin
                    want.prev_cp  = i_prev_code_point;
                    want.cur_cp   = i_cur_code_point;
                    want.prev_cls = lookup_class(i_prev_code_point);
                    want.cur_cls  = lookup_class(i_cur_code_point);
                    want.brk      = break_verdict(want.prev_cp, want.cur_cp,
                                                  want.prev_cls, want.cur_cls);
                    break_queue.push_back(want);
                end
            end
        end
        o_fail_count    <= mismatches;
        o_pending_count <= break_queue.size();
    end

endmodule

// File: verif/tb_line_break_opportunity_check_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_line_break_opportunity_check_core: testbench top for the line-break core
// Loads range tables, sets the number of entries searched and sends queries
// with random gaps on the input and random stalls on the output. A checker
// beside the core predicts every result; this module only makes stimulus and
// gives the verdict.
// ============================================================================
module tb_line_break_opportunity_check_core;
    import lbochk_pkg::*;

    localparam int DEPTH         = 2048;
    localparam int CP_MAX        = 'h10FFFF;
    localparam int MAX_GAP       = 12;
    // This many quiet cycles leave the core certainly idle.
    localparam int SETTLE_CYCLES = 40;
    // Cycles without any accepted item before the run is declared hung.
    localparam int IDLE_LIMIT    = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [10:0] entry_index;
    t_cp         entry_low;
    t_cp         entry_high;
    t_cls        entry_class;
    t_cp         prev_cp;
    t_cp         cur_cp;
    logic        out_valid;
    logic        out_stall;
    logic        break_allowed;
    t_cls        prev_class;
    t_cls        cur_class;

    int fail_count;
    int pending_count;

    // When set, neither side idles: back-to-back items and no output stalls.
    bit quiet;

    // Stimulus copy of what was loaded, used only to aim code points at the
    // edges of real ranges.
    t_cp slot_low  [DEPTH];
    t_cp slot_high [DEPTH];
    int  slots_loaded;
    // Slots 0 to slots_ready-1 have all been written at some point.
    int  slots_ready;

    int stall_left;
    int out_hold;
    int idle_cycles;

    line_break_opportunity_check_core #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_action         (action),
        .i_entry_index    (entry_index),
        .i_entry_low      (entry_low),
        .i_entry_high     (entry_high),
        .i_entry_class    (entry_class),
        .i_prev_code_point(prev_cp),
        .i_cur_code_point (cur_cp),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_break_allowed  (break_allowed),
        .o_prev_class     (prev_class),
        .o_cur_class      (cur_class)
    );

    lbochk_break_checker #(
        .TABLE_DEPTH(DEPTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_action         (action),
        .i_entry_index    (entry_index),
        .i_entry_low      (entry_low),
        .i_entry_high     (entry_high),
        .i_entry_class    (entry_class),
        .i_prev_code_point(prev_cp),
        .i_cur_code_point (cur_cp),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_break_allowed  (break_allowed),
        .i_prev_class     (prev_class),
        .i_cur_class      (cur_class),
        .o_fail_count     (fail_count),
        .o_pending_count  (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The output side holds each result for a random number of cycles once it
    // shows up. The count only runs down while a result is waiting, so the
    // stall always lands on a real result rather than expiring during a search.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            out_hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
            stall_left <= out_hold;
            out_stall  <= (out_hold != 0);
        end else if (out_valid && stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (out_valid) begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one item after the drawn gap and returns at the edge where the
    // core takes it. With no gap the valid simply stays high for the next item.
    task automatic send_item(input logic act, input logic [10:0] idx, input t_cp lo,
                             input t_cp hi, input t_cls cls, input t_cp p, input t_cp c);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        entry_index <= idx;
        entry_low   <= lo;
        entry_high  <= hi;
        entry_class <= cls;
        prev_cp     <= p;
        cur_cp      <= c;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // The code-point fields of a load item are unused, so they carry noise.
    task automatic load_slot(input int idx, input int lo, input int hi, input t_cls cls);
        slot_low[idx]  = t_cp'(lo);
        slot_high[idx] = t_cp'(hi);
        send_item(ACT_LOAD, 11'(idx), t_cp'(lo), t_cp'(hi), cls,
                  t_cp'($urandom_range(0, CP_MAX)), t_cp'($urandom_range(0, CP_MAX)));
    endtask

    // Likewise the entry fields of a query item are noise.
    task automatic ask_break(input t_cp p, input t_cp c);
        send_item(ACT_QUERY, 11'($urandom), t_cp'($urandom_range(0, CP_MAX)),
                  t_cp'($urandom_range(0, CP_MAX)), t_cls'($urandom), p, c);
    endtask

    // Mostly the six ruled classes, so that the class rules get exercised.
    function automatic t_cls pick_class();
        if ($urandom_range(0, 4) != 0) begin
            return t_cls'($urandom_range(0, 5));
        end
        return t_cls'($urandom_range(6, 63));
    endfunction

    // An entry count whose search never reaches an unwritten slot: either one
    // within the written prefix, or one past the depth, where the whole table
    // is searched and the first probe always hits the full-range entry in the
    // middle slot.
    function automatic int safe_count();
        if ($urandom_range(0, 1) == 0) begin
            return $urandom_range(0, slots_ready);
        end
        return $urandom_range(DEPTH, 4095);
    endfunction

    // Code points aimed at range edges, at the fixed rule points and at the
    // printable ASCII block, with the rest spread over the whole space.
    function automatic t_cp pick_cp();
        int roll;
        int s;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 40 && slots_loaded > 0) begin
            s = $urandom_range(0, slots_loaded - 1);
            case ($urandom_range(0, 4))
                0: v = int'(slot_low[s]);
                1: v = int'(slot_high[s]);
                2: v = int'(slot_low[s]) - 1;
                3: v = int'(slot_high[s]) + 1;
                default: v = $urandom_range(slot_low[s], slot_high[s]);
            endcase
        end else if (roll < 65) begin
            case ($urandom_range(0, 47))
                0: v = 'h0300;    1: v = 'h036F;    2: v = 'h02FF;    3: v = 'h0370;
                4: v = 'h1AB0;    5: v = 'h1DFF;    6: v = 'h20D0;    7: v = 'hFE2F;
                8: v = 'hFE00;    9: v = 'hFE0F;   10: v = 'hE0100;  11: v = 'hE01EF;
               12: v = 'h1F3FB;  13: v = 'h1F3FF;  14: v = 'hE0020;  15: v = 'hE007F;
               16: v = 'h200D;   17: v = 'h00A0;   18: v = 'h2007;   19: v = 'h202F;
               20: v = 'h2060;   21: v = 'h1F1E6;  22: v = 'h1F1FF;  23: v = 'h1F1E5;
               24: v = 'h30;     25: v = 'h39;     26: v = 'h0660;   27: v = 'h0669;
               28: v = 'h06F0;   29: v = 'h06F9;   30: v = 'hFF10;   31: v = 'hFF19;
               32: v = 'h2E;     33: v = 'h2C;     34: v = 'h066B;   35: v = 'h066C;
               36: v = 'hFF0E;   37: v = 'hFF0C;   38: v = 'h05D0;   39: v = 'h05EA;
               40: v = 'h05F0;   41: v = 'h05F2;   42: v = 'h27;     43: v = 'h22;
               44: v = 'h05F3;   45: v = 'h05F4;   46: v = 0;        default: v = CP_MAX;
            endcase
        end else if (roll < 75) begin
            v = $urandom_range('h20, 'h7F);
        end else begin
            v = $urandom_range(0, CP_MAX);
        end
        if (v < 0) v = 0;
        if (v > CP_MAX) v = CP_MAX;
        return t_cp'(v);
    endfunction

    // Writes slots 0 to count-1. An ordered table splits the code space into
    // equal slices with one range inside each, leaving gaps that read as ID.
    // Otherwise entries are placed at random, some of them inverted.
    task automatic fill_table(input int count, input bit ordered);
        int slice;
        int lo;
        int hi;
        slice = (CP_MAX + 1) / count;
        for (int k = 0; k < count; k++) begin
            if (ordered) begin
                lo = k * slice + $urandom_range(0, slice / 4);
                hi = lo + $urandom_range(0, slice / 2);
            end else begin
                lo = $urandom_range(0, CP_MAX);
                if ($urandom_range(0, 2) == 0) begin
                    hi = $urandom_range(0, CP_MAX);
                end else begin
                    hi = lo + $urandom_range(0, 4096);
                end
                if (hi > CP_MAX) hi = CP_MAX;
            end
            load_slot(k, lo, hi, pick_class());
        end
        slots_loaded = count;
        if (count > slots_ready) slots_ready = count;
    endtask

    // Drops valid, waits until every predicted result has come back, and
    // then lets the core finish any load still in flight.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entry_count(input int count);
        wait_drained();
        cfg_data <= 12'(count);
        cfg_we   <= 1'b1;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Queries with the odd table rewrite mixed in. Most rewrites keep the
    // range and change only its class; some drop a random range into the
    // slot and so break the ordering of the table.
    task automatic run_queries(input int count);
        int s;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                s = $urandom_range(0, slots_loaded - 1);
                if ($urandom_range(0, 3) != 0) begin
                    load_slot(s, int'(slot_low[s]), int'(slot_high[s]), pick_class());
                end else begin
                    load_slot(s, $urandom_range(0, CP_MAX), $urandom_range(0, CP_MAX),
                              pick_class());
                end
            end
            ask_break(pick_cp(), pick_cp());
        end
    endtask

    initial begin
        int table_size;
        int count;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        action       = ACT_LOAD;
        entry_index  = '0;
        entry_low    = '0;
        entry_high   = '0;
        entry_class  = '0;
        prev_cp      = '0;
        cur_cp       = '0;
        quiet        = 1'b0;
        slots_loaded = 0;
        slots_ready  = 0;
        idle_cycles  = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight out of reset no entry is searched, so both code points
        // must come back as ID and only the fixed code-point rules apply.
        ask_break(21'h000000, t_cp'(CP_MAX));
        ask_break(21'h000041, 21'h000020);

        // A small hand-made table: one range per ruled class, plus a range
        // starting at code point zero with the top class code and one ending
        // at the last code point. Anything else falls in a gap and reads ID.
        load_slot(0, 'h000000, 'h00001F, t_cls'(63));
        load_slot(1, 'h000020, 'h000020, CLS_SP);
        load_slot(2, 'h000021, 'h000021, CLS_NS);
        load_slot(3, 'h000028, 'h000028, CLS_OP);
        load_slot(4, 'h00002D, 'h00002D, CLS_HY);
        load_slot(5, 'h000041, 'h00007A, CLS_AL);
        load_slot(6, 'h100000, CP_MAX, CLS_ID);
        slots_loaded = 7;
        slots_ready  = 7;
        set_entry_count(7);

        // At least one query per rule of the chain, in chain order.
        ask_break(21'h000041, 21'h000300);    // combining mark after a letter
        ask_break(21'h000041, 21'h00200D);    // zero-width joiner
        ask_break(21'h0E0100, 21'h000041);    // variation selector in front
        ask_break(21'h000041, 21'h0000A0);    // no-break space
        ask_break(21'h0005D0, 21'h000022);    // Hebrew letter, then quote
        ask_break(21'h0005F4, 21'h0005EA);    // Hebrew quote, then letter
        ask_break(21'h000030, 21'h00002E);    // digit, then decimal point
        ask_break(21'h00066B, 21'h00FF10);    // separator, then digit
        ask_break(21'h01F1E6, 21'h01F1FF);    // regional indicator pair
        ask_break(21'h000041, 21'h000020);    // space follows
        ask_break(21'h000041, 21'h000021);    // non-starter follows
        ask_break(21'h000020, 21'h000041);    // after a space
        ask_break(21'h00002D, 21'h000041);    // after a hyphen
        ask_break(21'h000041, 21'h00002D);    // hyphen follows
        ask_break(21'h000028, 21'h000041);    // after an opening bracket
        ask_break(21'h000041, 21'h000061);    // letter, letter
        ask_break(21'h003000, 21'h000041);    // gap class, nothing else applies
        ask_break(21'h000000, t_cp'(CP_MAX)); // both ends of the code space

        // An ordered table of 128 ranges, searched in full.
        fill_table(128, 1'b1);
        set_entry_count(128);
        run_queries(150);

        // A range over the whole code space goes into the middle slot, and
        // another with a different class into the last slot. A count past the
        // depth searches the whole table, so its first probe lands in the
        // middle slot and hits there; an unclamped count would probe the last
        // slot instead. These two slots are never written again.
        load_slot(DEPTH / 2, 0, CP_MAX, CLS_AL);
        load_slot(DEPTH - 1, 0, CP_MAX, CLS_SP);
        set_entry_count(4095);
        run_queries(40);

        // Small tables, each followed by a different count: one entry, none
        // at all, one past the depth, and then mostly the table size with the
        // odd count that reaches into older entries or past the depth.
        for (int ph = 0; ph < 10; ph++) begin
            quiet <= (ph % 4 == 3);
            case (ph)
                0: begin
                    table_size = 1;
                    count      = 1;
                end
                1: begin
                    table_size = $urandom_range(2, 8);
                    count      = 0;
                end
                2: begin
                    table_size = $urandom_range(8, 64);
                    count      = DEPTH + 1;
                end
                default: begin
                    table_size = $urandom_range(2, 64);
                    count      = ($urandom_range(0, 4) == 0) ? safe_count() : table_size;
                end
            endcase
            fill_table(table_size, $urandom_range(0, 3) != 0);
            set_entry_count(count);
            run_queries(40);
        end

        wait_drained();
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
